// ----- rtl/sha256_pkg.sv -----
// shared types, constants and round helpers for the sha-256 engine
package sha256_pkg;

   localparam int WordWidth  = 32;
   localparam int CountWidth = 61;
   localparam int Rounds     = 64;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenPos  = 6'd56;
   localparam logic [5:0] LastPos = 6'd63;

   typedef logic [WordWidth-1:0] word_type;

   // control from the sequencer to the compression core
   typedef struct packed {
      logic     load;
      word_type load_word;
      logic     start;
      logic     init;
   } core_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_CSTART,
      ST_CWAIT,
      ST_OUT
   } seq_state_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_ADD
   } core_state_type;

   function automatic word_type initial_h(input logic [2:0] idx);
      word_type v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   localparam word_type RoundK [Rounds] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

// ----- rtl/sha256_hash_engine_unit.sv -----
// top level: byte intake, padding sequencer and digest output
// a byte that fills a block stalls further requests while that block is compressed
// (a start step, 64 rounds on the shared round unit, then a final add step)
// end of message pads one byte per cycle up to the length field, pausing while a full block
// compresses, then compresses once or twice; eight digest words follow, one per accepted response
// synchronous reset restores the initial hash words and clears the byte count
module sha256_hash_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_last
);

   sha256_pkg::seq_state_type state_ff, state_in;
   logic [sha256_pkg::CountWidth-1:0] count_ff, count_in;
   logic [5:0]  pos_ff, pos_in;
   logic [23:0] acc_ff, acc_in;
   logic        mark_ff, mark_in;
   logic        padding_ff, padding_in;
   logic        final_ff, final_in;
   logic [2:0]  idx_ff, idx_in;

   sha256_pkg::core_ctl_type ctl;
   logic                     core_done;
   sha256_pkg::word_type     hash [8];

   logic       req_take, rsp_take, push;
   logic [7:0] push_byte, len_byte;
   logic [63:0] bit_len;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign bit_len  = {count_ff, 3'b000};
   assign len_byte = bit_len[{3'd7 - pos_ff[2:0], 3'b000} +: 8];

   // byte to push this cycle
   always_comb begin
      push      = 1'b0;
      push_byte = req_data_byte;
      case (state_ff)
         sha256_pkg::ST_IDLE: push = req_take && req_byte_present;
         sha256_pkg::ST_PAD: begin
            push      = !mark_ff || (pos_ff != sha256_pkg::LenPos);
            push_byte = mark_ff ? 8'h00 : sha256_pkg::PadByte;
         end
         sha256_pkg::ST_LEN: begin
            push      = 1'b1;
            push_byte = len_byte;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_byte_present && pos_ff == sha256_pkg::LastPos)
                  state_in = sha256_pkg::ST_CSTART;
               else if (req_end_of_message)
                  state_in = sha256_pkg::ST_PAD;
            end
         end
         sha256_pkg::ST_PAD: begin
            if (push && pos_ff == sha256_pkg::LastPos)
               state_in = sha256_pkg::ST_CSTART;
            else if (mark_ff && pos_ff == sha256_pkg::LenPos)
               state_in = sha256_pkg::ST_LEN;
         end
         sha256_pkg::ST_LEN:
            if (pos_ff == sha256_pkg::LastPos) state_in = sha256_pkg::ST_CSTART;
         sha256_pkg::ST_CSTART: state_in = sha256_pkg::ST_CWAIT;
         sha256_pkg::ST_CWAIT: begin
            if (core_done) begin
               if (final_ff)        state_in = sha256_pkg::ST_OUT;
               else if (padding_ff) state_in = sha256_pkg::ST_PAD;
               else                 state_in = sha256_pkg::ST_IDLE;
            end
         end
         sha256_pkg::ST_OUT:
            if (rsp_take && idx_ff == 3'd7) state_in = sha256_pkg::ST_IDLE;
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   // sequencer registers update
   always_comb begin
      count_in   = count_ff;
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      mark_in    = mark_ff;
      padding_in = padding_ff;
      final_in   = final_ff;
      idx_in     = idx_ff;
      if (push) begin
         pos_in = pos_ff + 6'd1;
         acc_in = {acc_ff[15:0], push_byte};
      end
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_byte_present) count_in = count_ff + 1'b1;
               if (req_end_of_message) padding_in = 1'b1;
            end
         end
         sha256_pkg::ST_PAD: if (push) mark_in = 1'b1;
         sha256_pkg::ST_LEN: if (pos_ff == sha256_pkg::LastPos) final_in = 1'b1;
         sha256_pkg::ST_OUT: begin
            if (rsp_take) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  count_in   = '0;
                  pos_in     = '0;
                  mark_in    = 1'b0;
                  padding_in = 1'b0;
                  final_in   = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // core control
   always_comb begin
      ctl.load      = push && (pos_ff[1:0] == 2'b11);
      ctl.load_word = {acc_ff, push_byte};
      ctl.start     = (state_ff == sha256_pkg::ST_CSTART);
      ctl.init      = rsp_take && idx_ff == 3'd7;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha256_pkg::ST_IDLE;
         count_ff   <= '0;
         pos_ff     <= '0;
         mark_ff    <= 1'b0;
         padding_ff <= 1'b0;
         final_ff   <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         pos_ff     <= pos_in;
         mark_ff    <= mark_in;
         padding_ff <= padding_in;
         final_ff   <= final_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   sha256_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .done  (core_done),
      .hash  (hash)
   );

   // outputs
   assign req_stall       = (state_ff != sha256_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == sha256_pkg::ST_OUT);
   assign rsp_digest_word = hash[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_digest_last = (idx_ff == 3'd7);

endmodule

// ----- rtl/sha256_core.sv -----
// sha-256 compression core: message window, working words and hash state
module sha256_core (
   input  logic                        clock,
   input  logic                        reset,
   input  sha256_pkg::core_ctl_type    ctl,
   output logic                        done,
   output sha256_pkg::word_type        hash [8]
);

   sha256_pkg::core_state_type state_ff, state_in;
   sha256_pkg::word_type win_ff [16];
   sha256_pkg::word_type win_in [16];
   sha256_pkg::word_type hash_ff [8];
   sha256_pkg::word_type hash_in [8];
   sha256_pkg::word_type wv_ff [8];
   sha256_pkg::word_type wv_in [8];
   logic [5:0] rnd_ff, rnd_in;

   sha256_pkg::word_type big0, big1, ch, maj, t1, t2, sig0, sig1, sched;

   // round and schedule arithmetic
   always_comb begin
      big1  = sha256_pkg::rotr(wv_ff[4], 6) ^ sha256_pkg::rotr(wv_ff[4], 11)
            ^ sha256_pkg::rotr(wv_ff[4], 25);
      ch    = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      big0  = sha256_pkg::rotr(wv_ff[0], 2) ^ sha256_pkg::rotr(wv_ff[0], 13)
            ^ sha256_pkg::rotr(wv_ff[0], 22);
      maj   = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t1    = wv_ff[7] + big1 + ch + sha256_pkg::RoundK[rnd_ff] + win_ff[0];
      t2    = big0 + maj;
      sig0  = sha256_pkg::rotr(win_ff[1], 7) ^ sha256_pkg::rotr(win_ff[1], 18)
            ^ (win_ff[1] >> 3);
      sig1  = sha256_pkg::rotr(win_ff[14], 17) ^ sha256_pkg::rotr(win_ff[14], 19)
            ^ (win_ff[14] >> 10);
      sched = sig1 + win_ff[9] + sig0 + win_ff[0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha256_pkg::CORE_IDLE:  if (ctl.start) state_in = sha256_pkg::CORE_ROUND;
         sha256_pkg::CORE_ROUND: if (rnd_ff == 6'd63) state_in = sha256_pkg::CORE_ADD;
         sha256_pkg::CORE_ADD:   state_in = sha256_pkg::CORE_IDLE;
         default:                state_in = sha256_pkg::CORE_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      win_in  = win_ff;
      wv_in   = wv_ff;
      hash_in = hash_ff;
      rnd_in  = rnd_ff;
      case (state_ff)
         sha256_pkg::CORE_IDLE: begin
            if (ctl.load) begin
               for (int j = 0; j < 15; j++) win_in[j] = win_ff[j+1];
               win_in[15] = ctl.load_word;
            end
            if (ctl.start) begin
               wv_in  = hash_ff;
               rnd_in = '0;
            end
            if (ctl.init) begin
               for (int j = 0; j < 8; j++) hash_in[j] = sha256_pkg::initial_h(3'(j));
            end
         end
         sha256_pkg::CORE_ROUND: begin
            for (int j = 0; j < 15; j++) win_in[j] = win_ff[j+1];
            win_in[15] = sched;
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            rnd_in   = rnd_ff + 6'd1;
         end
         sha256_pkg::CORE_ADD: begin
            for (int j = 0; j < 8; j++) hash_in[j] = hash_ff[j] + wv_ff[j];
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::CORE_IDLE;
         for (int j = 0; j < 8; j++) hash_ff[j] <= sha256_pkg::initial_h(3'(j));
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      wv_ff  <= wv_in;
      rnd_ff <= rnd_in;
   end

   assign done = (state_ff == sha256_pkg::CORE_ADD);
   assign hash = hash_ff;

endmodule
